[sv/tet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the touch event tracker: panel geometry,
// command and event codes, register indexes, and the config/result words.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int PANEL_W = 240;
  localparam int PANEL_H = 320;

  // largest clamped raw coordinates
  localparam logic [11:0] RAW_X_MAX = 12'(PANEL_W - 1);
  localparam logic [11:0] RAW_Y_MAX = 12'(PANEL_H - 1);

  localparam int CX_W = 9;
  localparam int CY_W = 8;

  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_TILE = 1'b1;

  localparam logic [1:0] CFG_FLIP      = 2'd0;
  localparam logic [1:0] CFG_HOLDOFF   = 2'd1;
  localparam logic [1:0] CFG_HEARTBEAT = 2'd2;

  localparam logic [19:0] HOLDOFF_RST   = 20'd12000;
  localparam logic [25:0] HEARTBEAT_RST = 26'd2000000;

  typedef enum logic [1:0] {
    KIND_UP   = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_MOVE = 2'd2
  } kind_t;

  typedef struct packed {
    logic        flip;
    logic [19:0] holdoff;
    logic [25:0] heartbeat;
  } cfg_t;

  typedef struct packed {
    logic            send;
    logic            heartbeat;
    kind_t           kind;
    logic [CX_W-1:0] cx;
    logic [CY_W-1:0] cy;
    logic [7:0]      seq;
  } res_t;

endpackage

[sv/touch_event_tracker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_event_tracker_core
// Turns touch polls and tile marks into down/move/up packets and heartbeats.
// ----------------------------------------------------------------------------
// One word in, one result word out, for every input word. A word is taken
// every clock cycle while the output register is not stalled: the touch
// state, the hold-off and heartbeat compares and the clamp/rotate mapping
// are all combinational, and the result is loaded into an output register at
// the accepting edge and offered from the next cycle on. The input side stays
// ready while that register is empty or being drained in the same cycle. The
// configuration port is always ready; write it only while the block is idle.
module touch_event_tracker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  point_count,
  input  logic [11:0] raw_x,
  input  logic [11:0] raw_y,
  input  logic [31:0] now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send,
  output logic        heartbeat,
  output logic [1:0]  event_kind,
  output logic [8:0]  canvas_x,
  output logic [7:0]  canvas_y,
  output logic [7:0]  sequence_res
);
  import tet_pkg::*;

  cfg_t cfg;
  res_t res_next;
  res_t res;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flip      <= 1'b0;
      cfg.holdoff   <= HOLDOFF_RST;
      cfg.heartbeat <= HEARTBEAT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FLIP:      cfg.flip      <= cfg_data[0];
        CFG_HOLDOFF:   cfg.holdoff   <= cfg_data[19:0];
        CFG_HEARTBEAT: cfg.heartbeat <= cfg_data;
        default: ;
      endcase
    end
  end

  tet_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .point_count (point_count),
    .raw_x       (raw_x),
    .raw_y       (raw_y),
    .now_us      (now_us),
    .cfg         (cfg),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign send         = res.send;
  assign heartbeat    = res.heartbeat;
  assign event_kind   = res.kind;
  assign canvas_x     = res.cx;
  assign canvas_y     = res.cy;
  assign sequence_res = res.seq;

  // a word with no packet carries nothing else
  a_quiet_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !send |-> !heartbeat && event_kind == KIND_UP && canvas_x == '0
      && canvas_y == '0 && sequence_res == '0)
    else $error("non-send result carries data");

  // heartbeat is an up packet at the origin
  a_hb_shape : assert property (@(posedge clk) disable iff (rst)
    out_valid && heartbeat |-> send && event_kind == KIND_UP && canvas_x == '0
      && canvas_y == '0)
    else $error("malformed heartbeat");

  a_canvas_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> canvas_x < 9'(PANEL_H) && canvas_y < 8'(PANEL_W - 1) + 8'd1
      && event_kind != 2'd3)
    else $error("canvas point out of range");

  // every accepted word shows up in the output register next cycle
  a_accept_out : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word lost");

endmodule

[sv/tet_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_map
// Clamps a raw portrait point to the panel and rotates it into landscape,
// normal or turned 180 degrees.
// ----------------------------------------------------------------------------
module tet_map (
  input  logic                  flip,
  input  logic [11:0]           rx,
  input  logic [11:0]           ry,
  output logic [tet_pkg::CX_W-1:0] cx,
  output logic [tet_pkg::CY_W-1:0] cy
);
  import tet_pkg::*;

  logic [11:0] a;
  logic [11:0] b;
  logic [11:0] x_full;
  logic [11:0] y_full;

  always_comb begin
    a = (rx > RAW_X_MAX) ? RAW_X_MAX : rx;
    b = (ry > RAW_Y_MAX) ? RAW_Y_MAX : ry;
    if (flip) begin
      x_full = RAW_Y_MAX - b;
      y_full = a;
    end else begin
      x_full = b;
      y_full = RAW_X_MAX - a;
    end
  end

  assign cx = x_full[CX_W-1:0];
  assign cy = y_full[CY_W-1:0];

endmodule

[sv/tet_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_tracker
// Touch state, pending event and send timing. Works out the result of the
// word on its inputs and updates its state when that word is accepted.
// ----------------------------------------------------------------------------
module tet_tracker (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          command,
  input  logic [7:0]    point_count,
  input  logic [11:0]   raw_x,
  input  logic [11:0]   raw_y,
  input  logic [31:0]   now_us,
  input  tet_pkg::cfg_t cfg,
  output tet_pkg::res_t res
);
  import tet_pkg::*;

  logic            was_touched, was_touched_next;
  logic [11:0]     prev_raw_x, prev_raw_x_next;
  logic [11:0]     prev_raw_y, prev_raw_y_next;
  logic            pending, pending_next;
  kind_t           pending_kind, pending_kind_next;
  logic [CX_W-1:0] pending_x, pending_x_next;
  logic [CY_W-1:0] pending_y, pending_y_next;
  logic [7:0]      event_counter, event_counter_next;
  logic [31:0]     last_send_time, last_send_time_next;
  logic [31:0]     last_tile_time, last_tile_time_next;

  logic            is_poll;
  logic            touched;
  logic            latch;
  kind_t           latch_kind;
  logic [11:0]     map_rx, map_ry;
  logic [CX_W-1:0] map_cx;
  logic [CY_W-1:0] map_cy;
  logic            quiet;
  logic            hb_due;

  assign is_poll = (command == CMD_POLL);
  assign touched = (point_count == 8'd1) || (point_count == 8'd2);

  // up events use the last touched position
  assign map_rx = touched ? raw_x : prev_raw_x;
  assign map_ry = touched ? raw_y : prev_raw_y;

  tet_map u_map (
    .flip (cfg.flip),
    .rx   (map_rx),
    .ry   (map_ry),
    .cx   (map_cx),
    .cy   (map_cy)
  );

  assign quiet  = (now_us - last_tile_time) >= {12'd0, cfg.holdoff};
  assign hb_due = (now_us - last_send_time) >= {6'd0, cfg.heartbeat};

  always_comb begin
    latch      = 1'b0;
    latch_kind = KIND_UP;
    if (is_poll) begin
      if (touched) begin
        latch      = !was_touched || (raw_x != prev_raw_x) || (raw_y != prev_raw_y);
        latch_kind = was_touched ? KIND_MOVE : KIND_DOWN;
      end else begin
        latch      = was_touched;
        latch_kind = KIND_UP;
      end
    end
  end

  always_comb begin
    was_touched_next    = was_touched;
    prev_raw_x_next     = prev_raw_x;
    prev_raw_y_next     = prev_raw_y;
    pending_next        = pending;
    pending_kind_next   = pending_kind;
    pending_x_next      = pending_x;
    pending_y_next      = pending_y;
    event_counter_next  = event_counter;
    last_send_time_next = last_send_time;
    last_tile_time_next = last_tile_time;
    res                 = '0;
    res.kind            = KIND_UP;

    if (!is_poll) begin
      last_tile_time_next = now_us;
    end else begin
      if (touched) begin
        was_touched_next = 1'b1;
        prev_raw_x_next  = raw_x;
        prev_raw_y_next  = raw_y;
      end else begin
        was_touched_next = 1'b0;
      end
      if (latch) begin
        pending_next       = 1'b1;
        pending_kind_next  = latch_kind;
        pending_x_next     = map_cx;
        pending_y_next     = map_cy;
        event_counter_next = event_counter + 8'd1;
      end
      if (quiet) begin
        if (pending_next) begin
          res.send            = 1'b1;
          res.kind            = pending_kind_next;
          res.cx              = pending_x_next;
          res.cy              = pending_y_next;
          res.seq             = event_counter_next;
          pending_next        = 1'b0;
          last_send_time_next = now_us;
        end else if (hb_due) begin
          res.send            = 1'b1;
          res.heartbeat       = 1'b1;
          res.seq             = event_counter_next;
          last_send_time_next = now_us;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_touched    <= 1'b0;
      prev_raw_x     <= '0;
      prev_raw_y     <= '0;
      pending        <= 1'b0;
      pending_kind   <= KIND_UP;
      pending_x      <= '0;
      pending_y      <= '0;
      event_counter  <= '0;
      last_send_time <= '0;
      last_tile_time <= '0;
    end else if (accept) begin
      was_touched    <= was_touched_next;
      prev_raw_x     <= prev_raw_x_next;
      prev_raw_y     <= prev_raw_y_next;
      pending        <= pending_next;
      pending_kind   <= pending_kind_next;
      pending_x      <= pending_x_next;
      pending_y      <= pending_y_next;
      event_counter  <= event_counter_next;
      last_send_time <= last_send_time_next;
      last_tile_time <= last_tile_time_next;
    end
  end

endmodule

[tb/sv/touch_event_tracker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_event_tracker_core_tb
// Self-checking bench for the touch event tracker. Directed words cover
// hold-off after reset, clamping, both rotations, tile hold-off and release,
// heartbeat boundaries, zero intervals, register width wrap and time wrap.
// Random touch gestures with tile marks and noise then run under four
// handshake idling phases. Every result word is checked against a
// cycle-free tracker kept in the bench.
// ----------------------------------------------------------------------------
module touch_event_tracker_core_tb;
  import tet_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [25:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_POLL;
  logic [7:0]  point_count = '0;
  logic [11:0] raw_x = '0;
  logic [11:0] raw_y = '0;
  logic [31:0] now_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        send;
  logic        heartbeat;
  logic [1:0]  event_kind;
  logic [8:0]  canvas_x;
  logic [7:0]  canvas_y;
  logic [7:0]  sequence_res;

  touch_event_tracker_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .point_count(point_count), .raw_x(raw_x), .raw_y(raw_y), .now_us(now_us),
    .out_valid(out_valid), .out_ready(out_ready), .send(send),
    .heartbeat(heartbeat), .event_kind(event_kind), .canvas_x(canvas_x),
    .canvas_y(canvas_y), .sequence_res(sequence_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker state mirrored in the bench
  logic        flip_q;
  logic [19:0] holdoff_q;
  logic [25:0] beat_q;
  logic        touched_q;
  logic [11:0] last_x_q;
  logic [11:0] last_y_q;
  logic        pend_q;
  kind_t       pend_kind_q;
  logic [8:0]  pend_cx_q;
  logic [7:0]  pend_cy_q;
  logic [7:0]  seq_q;
  logic [31:0] sent_at_q;
  logic [31:0] tile_at_q;

  res_t        packets_due[$];
  logic [31:0] now_q = '0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          err_count = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          packets_out = 0;
  int          beats_out = 0;

  function automatic void reset_tracker();
    flip_q      = 1'b0;
    holdoff_q   = HOLDOFF_RST;
    beat_q      = HEARTBEAT_RST;
    touched_q   = 1'b0;
    last_x_q    = '0;
    last_y_q    = '0;
    pend_q      = 1'b0;
    pend_kind_q = KIND_UP;
    pend_cx_q   = '0;
    pend_cy_q   = '0;
    seq_q       = '0;
    sent_at_q   = '0;
    tile_at_q   = '0;
  endfunction

  // clamp to the panel, rotate into landscape, take the next sequence number
  function automatic void latch_pending(kind_t k, logic [11:0] rx, logic [11:0] ry);
    logic [11:0] a;
    logic [11:0] b;
    a = (rx > RAW_X_MAX) ? RAW_X_MAX : rx;
    b = (ry > RAW_Y_MAX) ? RAW_Y_MAX : ry;
    if (flip_q) begin
      pend_cx_q = 9'(PANEL_H - 1 - b);
      pend_cy_q = 8'(a);
    end else begin
      pend_cx_q = 9'(b);
      pend_cy_q = 8'(PANEL_W - 1 - a);
    end
    pend_kind_q = k;
    seq_q = seq_q + 8'd1;
    pend_q = 1'b1;
  endfunction

  function automatic res_t track_word(logic cmd, logic [7:0] cnt, logic [11:0] rx,
                                      logic [11:0] ry, logic [31:0] t);
    res_t r;
    logic hit;
    logic [31:0] since_tile;
    logic [31:0] since_send;
    r = '0;
    if (cmd == CMD_TILE) begin
      tile_at_q = t;
    end else begin
      hit = (cnt == 8'd1) || (cnt == 8'd2);
      if (hit) begin
        if (!touched_q || rx != last_x_q || ry != last_y_q)
          latch_pending(touched_q ? KIND_MOVE : KIND_DOWN, rx, ry);
        touched_q = 1'b1;
        last_x_q = rx;
        last_y_q = ry;
      end else if (touched_q) begin
        latch_pending(KIND_UP, last_x_q, last_y_q);
        touched_q = 1'b0;
      end
      since_tile = t - tile_at_q;
      since_send = t - sent_at_q;
      if (since_tile >= {12'd0, holdoff_q}) begin
        if (pend_q) begin
          r.send = 1'b1;
          r.kind = pend_kind_q;
          r.cx   = pend_cx_q;
          r.cy   = pend_cy_q;
          r.seq  = seq_q;
          pend_q = 1'b0;
          sent_at_q = t;
        end else if (since_send >= {6'd0, beat_q}) begin
          r.send      = 1'b1;
          r.heartbeat = 1'b1;
          r.kind      = KIND_UP;
          r.seq       = seq_q;
          sent_at_q   = t;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t due;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (packets_due.size() == 0) begin
        $error("result word with no input word outstanding");
        err_count++;
      end else begin
        due = packets_due.pop_front();
        check_field("send", 32'(due.send), 32'(send));
        check_field("heartbeat", 32'(due.heartbeat), 32'(heartbeat));
        check_field("event_kind", 32'(due.kind), 32'(event_kind));
        check_field("canvas_x", 32'(due.cx), 32'(canvas_x));
        check_field("canvas_y", 32'(due.cy), 32'(canvas_y));
        check_field("sequence_res", 32'(due.seq), 32'(sequence_res));
        if (due.send) packets_out++;
        if (due.heartbeat) beats_out++;
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_word(logic cmd, logic [7:0] cnt, logic [11:0] rx, logic [11:0] ry,
                           logic [31:0] t);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    command     <= cmd;
    point_count <= cnt;
    raw_x       <= rx;
    raw_y       <= ry;
    now_us      <= t;
    do @(posedge clk); while (!in_ready);
    packets_due.push_back(track_word(cmd, cnt, rx, ry, t));
    words_sent++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid and wait until every result is back; block is then idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (packets_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [25:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FLIP:      flip_q = data[0];
      CFG_HOLDOFF:   holdoff_q = data[19:0];
      CFG_HEARTBEAT: beat_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly small steps, some past the hold-off, a few toward the heartbeat,
  // and now and then a jump anywhere in the 32-bit range
  function automatic logic [31:0] step_time();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)      now_q = now_q + 32'($urandom_range(0, 3000));
    else if (pick < 80) now_q = now_q + 32'(holdoff_q) + 32'($urandom_range(0, 500));
    else if (pick < 95) now_q = now_q + 32'($urandom_range(0, beat_q));
    else                now_q = $urandom();
    return now_q;
  endfunction

  function automatic logic [11:0] pick_x();
    return ($urandom_range(99) < 70) ? 12'($urandom_range(0, PANEL_W))
                                     : 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [11:0] pick_y();
    return ($urandom_range(99) < 70) ? 12'($urandom_range(0, PANEL_H))
                                     : 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [7:0] lift_count();
    return ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
  endfunction

  task automatic run_gestures(int n);
    int stop;
    int pick;
    logic [11:0] x;
    logic [11:0] y;
    stop = words_sent + n;
    while (words_sent < stop) begin
      if ($urandom_range(99) < 85) begin
        x = pick_x();
        y = pick_y();
        send_word(CMD_POLL, 8'($urandom_range(1, 2)), x, y, step_time());
        repeat ($urandom_range(0, 8)) begin
          pick = $urandom_range(99);
          if (pick < 60) begin
            x = pick_x();
            y = pick_y();
            send_word(CMD_POLL, 8'($urandom_range(1, 2)), x, y, step_time());
          end else if (pick < 85) begin
            send_word(CMD_POLL, 8'($urandom_range(1, 2)), x, y, step_time());
          end else begin
            send_word(CMD_TILE, 8'($urandom_range(0, 255)), pick_x(), pick_y(), step_time());
          end
        end
        // some gestures never lift, so the next press turns into a move
        if ($urandom_range(99) < 90)
          send_word(CMD_POLL, lift_count(), pick_x(), pick_y(), step_time());
      end else begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), step_time());
      end
    end
  endtask

  task automatic run_phase(int send_idle, int recv_stall, logic flip, logic [25:0] hold,
                           logic [25:0] beat, int n);
    settle();
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    write_reg(CFG_FLIP, 26'(flip));
    write_reg(CFG_HOLDOFF, hold);
    write_reg(CFG_HEARTBEAT, beat);
    run_gestures(n);
  endtask

  task automatic test_reset_holdoff();
    send_word(CMD_POLL, 8'd1, 12'd4095, 12'd4095, 32'd100);
    send_word(CMD_POLL, 8'd2, 12'd4095, 12'd4095, 32'd12000);
  endtask

  task automatic test_clamp_and_moves();
    send_word(CMD_POLL, 8'd1, 12'd0, 12'd0, 32'd12010);
    send_word(CMD_POLL, 8'd1, 12'd239, 12'd319, 32'd12020);
    send_word(CMD_POLL, 8'd1, 12'd240, 12'd320, 32'd12030);
  endtask

  task automatic test_tile_holdoff();
    send_word(CMD_TILE, 8'd0, 12'd0, 12'd0, 32'd12040);
    send_word(CMD_POLL, 8'd0, 12'd0, 12'd0, 32'd12050);
    send_word(CMD_POLL, 8'd3, 12'd0, 12'd0, 32'd24040);
    send_word(CMD_POLL, 8'd255, 12'd0, 12'd0, 32'd24050);
  endtask

  task automatic test_heartbeat_edge();
    send_word(CMD_POLL, 8'd0, 12'd0, 12'd0, 32'd2024039);
    send_word(CMD_POLL, 8'd0, 12'd0, 12'd0, 32'd2024040);
  endtask

  task automatic test_flip_zero_intervals();
    settle();
    write_reg(CFG_FLIP, 26'd1);
    write_reg(CFG_HOLDOFF, 26'd0);
    write_reg(CFG_HEARTBEAT, 26'd0);
    send_word(CMD_POLL, 8'd1, 12'd4095, 12'd0, 32'd2100000);
    send_word(CMD_POLL, 8'd2, 12'd0, 12'd4095, 32'd2100001);
    send_word(CMD_POLL, 8'd0, 12'd0, 12'd0, 32'd2100002);
    send_word(CMD_POLL, 8'd0, 12'd0, 12'd0, 32'd2100002);
    send_word(CMD_TILE, 8'd0, 12'd0, 12'd0, 32'd2100003);
    send_word(CMD_POLL, 8'd0, 12'd0, 12'd0, 32'd2100003);
  endtask

  // register data wider than the field, and a hold-off that spans the wrap
  task automatic test_reg_and_time_wrap();
    settle();
    write_reg(CFG_FLIP, 26'h3FFFFFE);
    write_reg(CFG_HOLDOFF, 26'h3FFFFFF);
    write_reg(CFG_HEARTBEAT, 26'h3FFFFFF);
    send_word(CMD_TILE, 8'd1, 12'd100, 12'd200, 32'hFFFF_FFF0);
    send_word(CMD_POLL, 8'd1, 12'd100, 12'd200, 32'h000F_FFEE);
    send_word(CMD_POLL, 8'd1, 12'd100, 12'd200, 32'h000F_FFEF);
  endtask

  task automatic test_random_no_idle();
    run_phase(0, 0, 1'b0, 26'd0, 26'd1, 440);
  endtask

  task automatic test_random_sender_idle();
    run_phase(76, 0, 1'b1, 26'd1000000, 26'd60000000, 220);
    // hold off until every result is back, then carry on
    settle();
    run_gestures(220);
  endtask

  task automatic test_random_receiver_stall();
    run_phase(0, 76, 1'($urandom_range(0, 1)), 26'($urandom_range(0, 20000)),
              26'($urandom_range(1, 3000000)), 440);
  endtask

  task automatic test_random_both_idle();
    run_phase(7, 7, 1'b0, 26'(HOLDOFF_RST), 26'(HEARTBEAT_RST), 440);
  endtask

  initial begin
    reset_tracker();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_holdoff();
    test_clamp_and_moves();
    test_tile_holdoff();
    test_heartbeat_edge();
    test_flip_zero_intervals();
    test_reg_and_time_wrap();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    settle();
    if (packets_due.size() != 0) begin
      $error("%0d result words never arrived", packets_due.size());
      err_count++;
    end
    $display("covered %0d words, %0d results checked: %0d packets, %0d heartbeats",
             words_sent, results_seen, packets_out, beats_out);
    $display("both rotations, hold-off and heartbeat from zero to full width, four idling mixes");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
sv/tet_pkg.sv
sv/tet_map.sv
sv/tet_tracker.sv
sv/touch_event_tracker_core.sv
tb/sv/touch_event_tracker_core_tb.sv
